FILE: rtl/core/tcs_pkg.sv
// Shared types and constants of the twist command shaper.
package tcs_pkg;

    localparam int ALPHA_BITS = 30;
    localparam logic [30:0] ALPHA_ONE = 31'(1) << ALPHA_BITS;

    typedef enum logic [2:0] {
        REG_LIN_SPEED = 3'd0,
        REG_ANG_SPEED = 3'd1,
        REG_ACCEL_X   = 3'd2,
        REG_ACCEL_Y   = 3'd3,
        REG_ACCEL_W   = 3'd4,
        REG_TIMEOUT   = 3'd5,
        REG_EPSILON   = 3'd6,
        REG_STEP_TIME = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [30:0] lin_speed;
        logic [30:0] ang_speed;
        logic [30:0] accel_x;
        logic [30:0] accel_y;
        logic [30:0] accel_w;
        logic [30:0] timeout;
        logic [15:0] epsilon;
        logic [30:0] step_time;
    } t_cfg;

    typedef struct packed {
        logic       start;
        logic [5:0] qbits;
    } t_div_req;

    typedef struct packed {
        logic done;
    } t_div_rsp;

endpackage

FILE: rtl/core/tcs_if.sv
// Valid/ready channels for command items and shaped velocity results.
interface tcs_in_if;
    logic               valid;
    logic               ready;
    logic [0:0]         opcode;
    logic signed [31:0] cmd_vx;
    logic signed [31:0] cmd_vy;
    logic signed [31:0] cmd_wz;
    logic [19:0]        elapsed;
    modport source (output valid, opcode, cmd_vx, cmd_vy, cmd_wz, elapsed, input ready);
    modport sink (input valid, opcode, cmd_vx, cmd_vy, cmd_wz, elapsed, output ready);
endinterface

interface tcs_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_vx;
    logic signed [31:0] out_vy;
    logic signed [31:0] out_wz;
    logic [0:0]         timed_out;
    modport source (output valid, out_vx, out_vy, out_wz, timed_out, input ready);
    modport sink (input valid, out_vx, out_vy, out_wz, timed_out, output ready);
endinterface

FILE: rtl/core/tcs_regs.sv
// APB configuration registers of the twist command shaper.
module tcs_regs
    import tcs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);
    t_cfg     r_cfg;
    t_reg_idx idx;

    assign idx    = t_reg_idx'(paddr[4:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lin_speed <= 31'd32768;
            r_cfg.ang_speed <= 31'd655360;
            r_cfg.accel_x   <= 31'd13107;
            r_cfg.accel_y   <= 31'd13107;
            r_cfg.accel_w   <= 31'd655360;
            r_cfg.timeout   <= 31'd65536;
            r_cfg.epsilon   <= 16'd1;
            r_cfg.step_time <= 31'd6554;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                REG_LIN_SPEED: r_cfg.lin_speed <= pwdata[30:0];
                REG_ANG_SPEED: r_cfg.ang_speed <= pwdata[30:0];
                REG_ACCEL_X:   r_cfg.accel_x   <= pwdata[30:0];
                REG_ACCEL_Y:   r_cfg.accel_y   <= pwdata[30:0];
                REG_ACCEL_W:   r_cfg.accel_w   <= pwdata[30:0];
                REG_TIMEOUT:   r_cfg.timeout   <= pwdata[30:0];
                REG_EPSILON:   r_cfg.epsilon   <= pwdata[15:0];
                REG_STEP_TIME: r_cfg.step_time <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_LIN_SPEED: prdata = {1'b0, r_cfg.lin_speed};
            REG_ANG_SPEED: prdata = {1'b0, r_cfg.ang_speed};
            REG_ACCEL_X:   prdata = {1'b0, r_cfg.accel_x};
            REG_ACCEL_Y:   prdata = {1'b0, r_cfg.accel_y};
            REG_ACCEL_W:   prdata = {1'b0, r_cfg.accel_w};
            REG_TIMEOUT:   prdata = {1'b0, r_cfg.timeout};
            REG_EPSILON:   prdata = {16'd0, r_cfg.epsilon};
            REG_STEP_TIME: prdata = {1'b0, r_cfg.step_time};
            default:       prdata = 32'd0;
        endcase
    end
endmodule

FILE: rtl/core/tcs_div.sv
// Restoring divider, one quotient bit per cycle.
module tcs_div
    import tcs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    input  logic [63:0] i_dividend,
    input  logic [32:0] i_divisor,
    output t_div_rsp    o_rsp,
    output logic [31:0] o_quot
);
    logic [32:0] r_rem;
    logic [31:0] r_lo;
    logic [31:0] r_q;
    logic [32:0] r_div;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [33:0] trial;
    logic        ge;
    logic [33:0] diff;

    assign trial = {r_rem, r_lo[31]};
    assign ge    = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.qbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The top part of the dividend is known to be below the divisor.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= 33'(i_dividend >> i_req.qbits);
            r_lo  <= i_dividend[31:0] << (6'd32 - i_req.qbits);
            r_q   <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[32:0] : trial[32:0];
            r_lo  <= {r_lo[30:0], 1'b0};
            r_q   <= {r_q[30:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_quot     = r_q;
endmodule

FILE: rtl/core/twist_command_shaper.sv
// Twist command shaper: a command beat sets a clipped target velocity (no result); a tick
// beat ages the command and steps the output toward the target under acceleration limits,
// yielding one result. One shared 33x32 multiplier, a one-bit-per-cycle square root and a
// one-bit-per-cycle divider do all arithmetic under a sequencer, one item at a time. A
// command runs the square root, and two divisions of 32 quotient bits when the magnitude
// is clipped; a tick that times out zeroes the output without stepping, otherwise each of
// the three axes may need a division of 30 quotient bits. The result sits in an output
// register, so the next item is taken while it waits; a tick that finishes while the
// previous result is still unaccepted waits for it.
module twist_command_shaper
    import tcs_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcs_in_if.sink      i_in,
    tcs_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    typedef enum logic [15:0] {
        S_IDLE = 16'h0001, S_SQX  = 16'h0002, S_SQY  = 16'h0004, S_SUM  = 16'h0008,
        S_SQRT = 16'h0010, S_CDEC = 16'h0020, S_SMUL = 16'h0040, S_SDST = 16'h0080,
        S_SDIV = 16'h0100, S_CFIN = 16'h0200, S_TAGE = 16'h0400, S_TMUL = 16'h0800,
        S_TALP = 16'h1000, S_TDIV = 16'h2000, S_TSTP = 16'h4000, S_OUT  = 16'h8000
    } t_state;

    t_cfg     cfg;
    t_state   r_state;
    t_div_req div_req;
    t_div_rsp div_rsp;
    logic [63:0] div_dividend;
    logic [32:0] div_divisor;
    logic [31:0] div_quot;

    logic signed [31:0] r_vx, r_vy, r_wz;
    logic [19:0]        r_el;
    logic signed [31:0] r_tgt [3];
    logic signed [31:0] r_cur [3];
    logic signed [32:0] r_d [3];
    logic [31:0] r_age;
    logic [63:0] r_prod, r_acc, r_x, r_r, r_bit;
    logic [19:0] r_dt;
    logic [30:0] r_amin;
    logic [1:0]  r_ax;
    logic        r_apply;
    logic        r_timed;
    logic        r_tout;
    logic        r_ov;
    logic signed [31:0] r_ox, r_oy, r_ow;

    logic [32:0] mul_a;
    logic [31:0] mul_b;
    logic [64:0] mul_p;
    logic [31:0] abs_vx, abs_vy, mag;
    logic signed [32:0] d_sel;
    logic [32:0] ad;
    logic [63:0] maxd;
    logic        no_div;
    logic [63:0] rb;
    logic [32:0] age_sum;
    logic [31:0] age_new;
    logic [30:0] acc_sel;
    logic [30:0] alpha_q;
    logic [63:0] step_s;
    logic signed [33:0] cur_new;
    logic signed [32:0] lim_w;

    tcs_regs u_regs (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .o_cfg(cfg)
    );

    tcs_div u_div (
        .i_clk, .i_rst_n, .i_req(div_req), .i_dividend(div_dividend),
        .i_divisor(div_divisor), .o_rsp(div_rsp), .o_quot(div_quot)
    );

    assign abs_vx  = r_vx[31] ? 32'(-r_vx) : 32'(r_vx);
    assign abs_vy  = r_vy[31] ? 32'(-r_vy) : 32'(r_vy);
    assign mag     = r_r[31:0];
    assign d_sel   = r_d[r_ax];
    assign ad      = d_sel[32] ? 33'(-d_sel) : 33'(d_sel);
    assign maxd    = r_prod >> FRAC_BITS;
    assign no_div  = ({31'd0, ad} <= maxd) || (maxd < {48'd0, cfg.epsilon});
    assign rb      = r_r + r_bit;
    assign age_sum = {1'b0, r_age} + {13'd0, r_el};
    assign age_new = age_sum[32] ? '1 : age_sum[31:0];
    assign step_s  = r_prod >> ALPHA_BITS;
    assign cur_new = d_sel[32] ? 34'(r_cur[r_ax]) - 34'(step_s[32:0])
                               : 34'(r_cur[r_ax]) + 34'(step_s[32:0]);
    assign lim_w   = {2'b00, cfg.ang_speed};
    assign alpha_q = no_div ? ALPHA_ONE : 31'(div_quot);

    always_comb begin
        unique case (r_ax)
            2'd0:    acc_sel = cfg.accel_x;
            2'd1:    acc_sel = cfg.accel_y;
            default: acc_sel = cfg.accel_w;
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (r_state)
            S_SQX:   begin mul_a = {1'b0, abs_vx}; mul_b = abs_vx; end
            S_SQY:   begin mul_a = {1'b0, abs_vy}; mul_b = abs_vy; end
            S_SMUL:  begin
                mul_a = (r_ax == 2'd0) ? {1'b0, abs_vx} : {1'b0, abs_vy};
                mul_b = {1'b0, cfg.lin_speed};
            end
            S_TMUL:  begin mul_a = {2'b00, acc_sel}; mul_b = {12'd0, r_dt}; end
            S_TSTP:  begin mul_a = ad; mul_b = {1'b0, r_amin}; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    always_comb begin
        div_req.start = 1'b0;
        div_req.qbits = 6'd32;
        div_dividend  = r_prod;
        div_divisor   = {1'b0, mag};
        if (r_state == S_SDST) begin
            div_req.start = 1'b1;
        end else if (r_state == S_TALP) begin
            div_req.start = !no_div;
            div_req.qbits = 6'(ALPHA_BITS);
            div_dividend  = maxd << ALPHA_BITS;
            div_divisor   = ad;
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ov;
    assign o_out.out_vx    = r_ox;
    assign o_out.out_vy    = r_oy;
    assign o_out.out_wz    = r_ow;
    assign o_out.timed_out = r_tout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_age   <= '0;
            r_ax    <= '0;
            for (int i = 0; i < 3; i++) begin
                r_tgt[i] <= '0;
                r_cur[i] <= '0;
            end
        end else begin
            if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_state <= i_in.opcode[0] ? S_TAGE : S_SQX;
                    end
                end
                S_SQX:  r_state <= S_SQY;
                S_SQY:  r_state <= S_SUM;
                S_SUM:  r_state <= S_SQRT;
                S_SQRT: begin
                    if (r_bit[0]) begin
                        r_state <= S_CDEC;
                    end
                end
                S_CDEC: begin
                    r_ax <= 2'd0;
                    if (mag <= {16'd0, cfg.epsilon}) begin
                        r_tgt[0] <= '0;
                        r_tgt[1] <= '0;
                        r_state  <= S_CFIN;
                    end else if (mag > {1'b0, cfg.lin_speed}) begin
                        r_state <= S_SMUL;
                    end else begin
                        r_tgt[0] <= r_vx;
                        r_tgt[1] <= r_vy;
                        r_state  <= S_CFIN;
                    end
                end
                S_SMUL: r_state <= S_SDST;
                S_SDST: r_state <= S_SDIV;
                S_SDIV: begin
                    if (div_rsp.done) begin
                        if (r_ax == 2'd0) begin
                            r_tgt[0] <= r_vx[31] ? -$signed(div_quot) : $signed(div_quot);
                            r_ax     <= 2'd1;
                            r_state  <= S_SMUL;
                        end else begin
                            r_tgt[1] <= r_vy[31] ? -$signed(div_quot) : $signed(div_quot);
                            r_state  <= S_CFIN;
                        end
                    end
                end
                S_CFIN: begin
                    if (33'(r_wz) > lim_w) begin
                        r_tgt[2] <= 32'(lim_w);
                    end else if (33'(r_wz) < -lim_w) begin
                        r_tgt[2] <= 32'(-lim_w);
                    end else begin
                        r_tgt[2] <= r_wz;
                    end
                    r_age   <= '0;
                    r_state <= S_IDLE;
                end
                S_TAGE: begin
                    r_age <= age_new;
                    r_ax  <= 2'd0;
                    if (age_new > {1'b0, cfg.timeout}) begin
                        for (int i = 0; i < 3; i++) begin
                            r_cur[i] <= '0;
                        end
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_TMUL;
                    end
                end
                S_TMUL: r_state <= S_TALP;
                S_TALP, S_TDIV: begin
                    if ((r_state == S_TALP && no_div) || div_rsp.done) begin
                        r_ax    <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                        r_state <= (r_ax == 2'd2) ? S_TSTP : S_TMUL;
                    end else begin
                        r_state <= S_TDIV;
                    end
                end
                S_TSTP: begin
                    // Alternates between multiplying and applying the step to the axis, starting with a multiply.
                    if (r_apply) begin
                        r_cur[r_ax] <= cur_new[31:0];
                        r_ax        <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                        if (r_ax == 2'd2) begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ov || o_out.ready) begin
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_vx <= i_in.cmd_vx;
            r_vy <= i_in.cmd_vy;
            r_wz <= i_in.cmd_wz;
            r_el <= i_in.elapsed;
        end
        if (r_state == S_SQX || r_state == S_SQY || r_state == S_SMUL || r_state == S_TMUL
            || (r_state == S_TSTP && !r_apply)) begin
            r_prod <= mul_p[63:0];
        end
        if (r_state == S_SQY) begin
            r_acc <= r_prod;
        end
        if (r_state == S_SUM) begin
            r_x   <= r_acc + r_prod;
            r_r   <= '0;
            r_bit <= 64'd1 << 62;
        end
        if (r_state == S_SQRT) begin
            if (r_x >= rb) begin
                r_x <= r_x - rb;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (r_state == S_TAGE) begin
            r_dt    <= ({11'd0, r_el} < cfg.step_time) ? r_el : cfg.step_time[19:0];
            r_amin  <= ALPHA_ONE;
            r_timed <= (age_new > {1'b0, cfg.timeout});
            r_apply <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_d[i] <= 33'(r_tgt[i]) - 33'(r_cur[i]);
            end
        end
        if ((r_state == S_TALP && no_div) || (r_state == S_TDIV && div_rsp.done)) begin
            if (alpha_q < r_amin) begin
                r_amin <= alpha_q;
            end
        end
        if (r_state == S_TSTP) begin
            r_apply <= !r_apply;
        end
        if (r_state == S_OUT && (!r_ov || o_out.ready)) begin
            r_ox   <= r_cur[0];
            r_oy   <= r_cur[1];
            r_ow   <= r_cur[2];
            r_tout <= r_timed;
        end
    end
endmodule

FILE: verif/twist_command_shaper_test.sv
`timescale 1ns / 100ps
// Testbench of the twist command shaper: directed and random command and tick beats.
module twist_command_shaper_test
    import tcs_pkg::*;
();

    typedef struct {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] wz;
        logic               timed;
    } t_shaped;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    tcs_in_if  in_ch ();
    tcs_out_if out_ch ();

    twist_command_shaper u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state.
    logic [63:0]  lin_lim, ang_lim, acc_x, acc_y, acc_w, tmo, eps, step_max;
    longint       tgt [3];
    longint       cur [3];
    logic [63:0]  age;
    t_shaped      shaped_q [$];

    int  n_err = 0;
    int  n_cycles = 0;
    bit  send_idle_on = 1'b1;
    bit  recv_idle_on = 1'b1;
    int  hold_cycles = 0;

    task automatic report(input string what);
        n_err++;
        $display("mismatch: %s", what);
    endtask

    function automatic logic [63:0] abs64(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] step_fraction(input longint d, input logic [63:0] acc,
                                                  input logic [63:0] dt);
        logic [63:0] ad, maxd;
        ad = abs64(d);
        maxd = (acc * dt) >> 16;
        if (ad <= maxd || maxd < eps) return 64'd1 << 30;
        return (maxd << 30) / ad;
    endfunction

    function automatic longint clip_axis(input longint v, input logic [63:0] mag);
        logic [63:0] q;
        q = (abs64(v) * lin_lim) / mag;
        return v < 0 ? -longint'(q) : longint'(q);
    endfunction

    task automatic predict_command(input logic signed [31:0] vx, vy, wz);
        longint x, y, w;
        logic [63:0] mag;
        x = vx; y = vy; w = wz;
        mag = root_floor(abs64(x) * abs64(x) + abs64(y) * abs64(y));
        if (mag > eps) begin
            if (mag > lin_lim) begin
                x = clip_axis(x, mag);
                y = clip_axis(y, mag);
            end
        end else begin
            x = 0;
            y = 0;
        end
        if (w > longint'(ang_lim)) w = ang_lim;
        if (w < -longint'(ang_lim)) w = -longint'(ang_lim);
        tgt[0] = x; tgt[1] = y; tgt[2] = w;
        age = 0;
    endtask

    task automatic predict_tick(input logic [19:0] el);
        logic [63:0] dt, a, amin, s;
        longint d [3];
        t_shaped r;
        dt = (el < step_max) ? el : step_max;
        age += el;
        if (age > 64'hFFFF_FFFF) age = 64'hFFFF_FFFF;
        r.timed = 1'b0;
        if (age > tmo) begin
            for (int i = 0; i < 3; i++) cur[i] = 0;
            r.timed = 1'b1;
        end else begin
            for (int i = 0; i < 3; i++) d[i] = tgt[i] - cur[i];
            amin = step_fraction(d[0], acc_x, dt);
            a = step_fraction(d[1], acc_y, dt);
            if (a < amin) amin = a;
            a = step_fraction(d[2], acc_w, dt);
            if (a < amin) amin = a;
            for (int i = 0; i < 3; i++) begin
                s = (abs64(d[i]) * amin) >> 30;
                cur[i] += d[i] < 0 ? -longint'(s) : longint'(s);
            end
        end
        r.vx = cur[0][31:0];
        r.vy = cur[1][31:0];
        r.wz = cur[2][31:0];
        shaped_q.push_back(r);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = {idx, 2'b00}; pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            REG_LIN_SPEED: lin_lim = val[30:0];
            REG_ANG_SPEED: ang_lim = val[30:0];
            REG_ACCEL_X:   acc_x = val[30:0];
            REG_ACCEL_Y:   acc_y = val[30:0];
            REG_ACCEL_W:   acc_w = val[30:0];
            REG_TIMEOUT:   tmo = val[30:0];
            REG_EPSILON:   eps = val[15:0];
            REG_STEP_TIME: step_max = val[30:0];
            default: ;
        endcase
    endtask

    // Sends one beat; the prediction is made at acceptance.
    task automatic send_beat(input bit is_tick, input logic signed [31:0] vx, vy, wz,
                             input logic [19:0] el);
        @(negedge i_clk);
        while (send_idle_on && $urandom_range(99) < 32) @(negedge i_clk);
        in_ch.valid = 1'b1;
        in_ch.opcode = is_tick;
        in_ch.cmd_vx = vx; in_ch.cmd_vy = vy; in_ch.cmd_wz = wz;
        in_ch.elapsed = el;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (is_tick) predict_tick(el);
        else predict_command(vx, vy, wz);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic send_command(input logic signed [31:0] vx, vy, wz);
        send_beat(1'b0, vx, vy, wz, 20'($urandom));
    endtask

    task automatic send_tick(input logic [19:0] el);
        send_beat(1'b1, $urandom, $urandom, $urandom, el);
    endtask

    task automatic drain();
        while (shaped_q.size() != 0) @(posedge i_clk);
        // A command beat gives no result and may still be in the square root and divider.
        repeat (150) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_speed();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(131072)) - 65536;
            2: return $signed($urandom_range(2000000)) - 1000000;
            default: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        endcase
    endfunction

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > 2_000_000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, plus an optional long hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            out_ch.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            out_ch.ready <= !(recv_idle_on && $urandom_range(99) < 32);
        end
    end

    always @(posedge i_clk) begin
        t_shaped e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (shaped_q.size() == 0) begin
                report("result with nothing expected");
            end else begin
                e = shaped_q.pop_front();
                if (out_ch.out_vx !== e.vx)
                    report($sformatf("vx got %0d exp %0d", out_ch.out_vx, e.vx));
                if (out_ch.out_vy !== e.vy)
                    report($sformatf("vy got %0d exp %0d", out_ch.out_vy, e.vy));
                if (out_ch.out_wz !== e.wz)
                    report($sformatf("wz got %0d exp %0d", out_ch.out_wz, e.wz));
                if (out_ch.timed_out !== e.timed)
                    report($sformatf("timed_out got %0b exp %0b", out_ch.timed_out, e.timed));
            end
        end
    end

    task automatic test_defaults_directed();
        send_tick(20'd655);
        send_command(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_tick(20'd0);
        send_tick(20'hFFFFF);
        send_command(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_tick(20'd6554);
        send_tick(20'd100);
        send_command(32'sd1, 32'sd0, -32'sd5);
        send_tick(20'd1000);
        send_command(32'sd20000, -32'sd10000, 32'sd3000);
        repeat (4) send_tick(20'd6554);
        send_tick(20'd65536);
        send_tick(20'd1);
        drain();
    endtask

    task automatic test_register_extremes();
        write_reg(REG_LIN_SPEED, 32'h7FFF_FFFF);
        write_reg(REG_ANG_SPEED, 32'hFFFF_FFFF);
        write_reg(REG_ACCEL_X, 32'h7FFF_FFFF);
        write_reg(REG_ACCEL_Y, 32'h0);
        write_reg(REG_ACCEL_W, 32'h7FFF_FFFF);
        write_reg(REG_TIMEOUT, 32'h7FFF_FFFF);
        write_reg(REG_EPSILON, 32'h0);
        write_reg(REG_STEP_TIME, 32'h7FFF_FFFF);
        send_command(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_tick(20'hFFFFF);
        send_tick(20'hFFFFF);
        drain();
        write_reg(REG_EPSILON, 32'hFFFF);
        write_reg(REG_LIN_SPEED, 32'h0);
        write_reg(REG_ANG_SPEED, 32'h0);
        write_reg(REG_TIMEOUT, 32'h0);
        write_reg(REG_STEP_TIME, 32'h0);
        send_command(32'sd5, 32'sd5, 32'sd5);
        send_tick(20'd0);
        send_tick(20'd1);
        drain();
    endtask

    task automatic random_phase(input int n_items, input bit with_hold);
        for (int i = 0; i < n_items; i++) begin
            if (with_hold && i == 20) hold_cycles = 3000;
            if ($urandom_range(3) == 0)
                send_command(rand_speed(), rand_speed(), rand_speed());
            else
                send_tick(20'($urandom_range(3) == 0 ? $urandom : $urandom_range(8000)));
        end
        drain();
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 6; p++) begin
            write_reg(REG_LIN_SPEED, $urandom_range(p == 0 ? 1 : 3000000));
            write_reg(REG_ANG_SPEED, $urandom_range(2000000));
            write_reg(REG_ACCEL_X, $urandom_range(p == 5 ? 32'h7FFF_FFFF : 2000000));
            write_reg(REG_ACCEL_Y, $urandom_range(2000000));
            write_reg(REG_ACCEL_W, $urandom_range(2000000));
            write_reg(REG_TIMEOUT, $urandom_range(40000, 400000));
            write_reg(REG_EPSILON, $urandom_range(p == 3 ? 65535 : 40));
            write_reg(REG_STEP_TIME, $urandom_range(1000, 20000));
            recv_idle_on = (p != 2);
            send_idle_on = (p != 2);
            random_phase(100, p == 1);
        end
    endtask

    initial begin
        lin_lim = 32768; ang_lim = 655360; acc_x = 13107; acc_y = 13107;
        acc_w = 655360; tmo = 65536; eps = 1; step_max = 6554;
        for (int i = 0; i < 3; i++) begin
            tgt[i] = 0;
            cur[i] = 0;
        end
        age = 0;
        in_ch.valid = 1'b0;
        in_ch.opcode = '0;
        in_ch.cmd_vx = '0; in_ch.cmd_vy = '0; in_ch.cmd_wz = '0;
        in_ch.elapsed = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_defaults_directed();
        test_register_extremes();
        test_random_settings();
        if (n_err == 0 && shaped_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
